FILE: design/ert_pkg.sv
// Shared types, constant tables and elaboration-time helpers for the
// exp_range_reduced_taylor block. No dependencies.
package ert_pkg;

    localparam int MAX_TERMS = 20;   // deepest Taylor order the coefficient table serves
    localparam int EXP_N     = 16;   // largest |x0| the power tables serve
    localparam int INT_W     = 5;    // integer bits of the argument, sign included
    localparam int COEF_FRAC = 60;   // Horner sum fraction bits
    localparam int POS_FRAC  = 39;   // fraction bits of e^n, n >= 0
    localparam int NEG_FRAC  = 63;   // fraction bits of e^-n, n > 0
    localparam int E_FRAC    = 62;   // fraction bits of e and 1/e
    localparam int S_W       = 61;   // Horner sum width: e^0.5 * 2^60 < 2^61
    localparam int F_W       = 64;   // power factor width
    localparam int IDX_W     = 5;    // index into the power tables

    typedef logic [63:0]    u64_t;
    typedef logic [127:0]   u128_t;
    typedef logic [S_W-1:0] sum_t;
    typedef u64_t coef_tab_t [0:MAX_TERMS];
    typedef u64_t exp_tab_t  [0:EXP_N];

    // Power factor travelling alongside each word.
    typedef struct packed {
        logic           neg;     // factor is e^-n in Q.63, else e^n in Q.39
        logic [F_W-1:0] factor;
    } scale_t;

    localparam u64_t E_NUM = 64'd2718281828459;
    localparam u64_t E_DEN = 64'd1000000000000;

    // Restoring division, used only to build constants.
    function automatic u128_t udiv_fn(input u128_t num, input u128_t den);
        logic [128:0] rem;
        u128_t        quo;
        int           i;
        rem = '0;
        quo = '0;
        for (i = 127; i >= 0; i--) begin
            rem = {rem[127:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic u64_t mul_round_fn(input u64_t a, input u64_t b, input int sh);
        u128_t prod;
        prod = u128_t'(a) * u128_t'(b);
        prod = prod + (u128_t'(1) << (sh - 1));
        return u64_t'(prod >> sh);
    endfunction

    // round(num * 2^62 / den)
    function automatic u64_t ratio_q62_fn(input u64_t num, input u64_t den);
        u128_t q63;
        q63 = udiv_fn(u128_t'(num) << (E_FRAC + 1), u128_t'(den));
        return u64_t'((q63 + u128_t'(1)) >> 1);
    endfunction

    // round(2^60 / k!)
    function automatic coef_tab_t build_coef_fn();
        coef_tab_t tab;
        u64_t      fact;
        int        k;
        fact = u64_t'(1);
        for (k = 0; k <= MAX_TERMS; k++) begin
            if (k > 1) begin
                fact = fact * u64_t'(k);
            end
            tab[k] = u64_t'(udiv_fn(u128_t'((u64_t'(1) << COEF_FRAC) + (fact >> 1)),
                                    u128_t'(fact)));
        end
        return tab;
    endfunction

    function automatic exp_tab_t build_pow_fn(input u64_t base, input int frac);
        exp_tab_t tab;
        u64_t     p;
        int       i;
        p      = u64_t'(1) << frac;
        tab[0] = p;
        for (i = 1; i <= EXP_N; i++) begin
            p      = mul_round_fn(p, base, E_FRAC);
            tab[i] = p;
        end
        return tab;
    endfunction

    localparam u64_t      E_Q62     = ratio_q62_fn(E_NUM, E_DEN);
    localparam u64_t      INV_E_Q62 = ratio_q62_fn(E_DEN, E_NUM);
    localparam coef_tab_t COEF      = build_coef_fn();
    localparam exp_tab_t  EXP_POS   = build_pow_fn(E_Q62, POS_FRAC);
    localparam exp_tab_t  EXP_NEG   = build_pow_fn(INV_E_Q62, NEG_FRAC);

endpackage

FILE: design/ert_reduce.sv
// Range reduction: splits x into a nearest integer x0 and a remainder r,
// and looks up e^x0. Three register stages. Depends on ert_pkg.
module ert_reduce #(
    parameter int IN_FRAC_BITS = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     en,
    input  logic                                     valid_in,
    input  logic signed [IN_FRAC_BITS+ert_pkg::INT_W-1:0] x_in,
    output logic                                     valid_out,
    output logic [IN_FRAC_BITS-1:0]                  ra_out,
    output logic                                     rneg_out,
    output ert_pkg::scale_t                          scale_out
);

    localparam int IN_W = IN_FRAC_BITS + ert_pkg::INT_W;
    localparam logic [IN_W-1:0]         HALF_W = IN_W'(1) << (IN_FRAC_BITS - 1);
    localparam logic [IN_FRAC_BITS-1:0] HALF_L = IN_FRAC_BITS'(1) << (IN_FRAC_BITS - 1);

    logic                         v1_reg, v2_reg, v3_reg;
    logic                         vneg1_reg, vneg2_reg;
    logic [IN_W-1:0]              mag_reg;
    logic [IN_W-1:0]              x_bits, mag_next, rnd_sum;
    logic [ert_pkg::IDX_W-1:0]    n_reg;
    logic [IN_FRAC_BITS-1:0]      low_reg;
    logic                         ge_half, neg_pow;
    logic [IN_FRAC_BITS-1:0]      ra_next;
    logic                         rneg_next;
    ert_pkg::scale_t              scale_next;
    logic [IN_FRAC_BITS-1:0]      ra_reg;
    logic                         rneg_reg;
    ert_pkg::scale_t              scale_reg;

    // Stage 1: magnitude and sign.
    assign x_bits   = x_in;
    assign mag_next = x_bits[IN_W-1] ? (~x_bits + IN_W'(1)) : x_bits;

    // Stage 2: round the magnitude, ties away from zero.
    assign rnd_sum = mag_reg + HALF_W;

    // Stage 3: remainder magnitude, its sign, and the power factor.
    always_comb begin
        ge_half   = (low_reg >= HALF_L);
        ra_next   = ge_half ? (low_reg - HALF_L) : (HALF_L - low_reg);
        rneg_next = ge_half ? (vneg2_reg && (low_reg != HALF_L)) : !vneg2_reg;
        neg_pow   = vneg2_reg && (n_reg != '0);
        scale_next.neg    = neg_pow;
        scale_next.factor = neg_pow ? ert_pkg::EXP_NEG[n_reg] : ert_pkg::EXP_POS[n_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vneg1_reg <= x_bits[IN_W-1];
            mag_reg   <= mag_next;
            vneg2_reg <= vneg1_reg;
            n_reg     <= rnd_sum[IN_W-1:IN_FRAC_BITS];
            low_reg   <= rnd_sum[IN_FRAC_BITS-1:0];
            ra_reg    <= ra_next;
            rneg_reg  <= rneg_next;
            scale_reg <= scale_next;
        end
    end

    assign valid_out = v3_reg;
    assign ra_out    = ra_reg;
    assign rneg_out  = rneg_reg;
    assign scale_out = scale_reg;

endmodule

FILE: design/ert_horner_step.sv
// One Horner step s = c_K +/- round(s * |r|): a multiply stage, then a
// round and add/subtract stage. Depends on ert_pkg.
module ert_horner_step #(
    parameter int IN_FRAC_BITS = 16,
    parameter int K            = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    valid_in,
    input  ert_pkg::sum_t           s_in,
    input  logic [IN_FRAC_BITS-1:0] ra_in,
    input  logic                    rneg_in,
    input  ert_pkg::scale_t         scale_in,
    output logic                    valid_out,
    output ert_pkg::sum_t           s_out,
    output logic [IN_FRAC_BITS-1:0] ra_out,
    output logic                    rneg_out,
    output ert_pkg::scale_t         scale_out
);

    localparam int S_W = ert_pkg::S_W;
    localparam int PW  = S_W + IN_FRAC_BITS;
    localparam logic [PW-1:0]  HALF = PW'(1) << (IN_FRAC_BITS - 1);
    localparam logic [S_W-1:0] COEF_K = ert_pkg::sum_t'(ert_pkg::COEF[K]);

    logic                    va_reg, vb_reg;
    logic [PW-1:0]           prod_next, prod_reg;
    logic [IN_FRAC_BITS-1:0] ra_a_reg, ra_b_reg;
    logic                    rneg_a_reg, rneg_b_reg;
    ert_pkg::scale_t         scale_a_reg, scale_b_reg;
    logic [S_W-1:0]          term;
    logic [S_W:0]            acc;
    logic [S_W-1:0]          s_next, s_reg;

    // Fold the rounding half into the multiply.
    assign prod_next = PW'(s_in) * PW'(ra_in) + HALF;
    assign term      = prod_reg[PW-1:IN_FRAC_BITS];

    // Clamp at zero when the term exceeds the coefficient.
    always_comb begin
        if (rneg_a_reg) begin
            acc    = {1'b0, COEF_K} - {1'b0, term};
            s_next = acc[S_W] ? '0 : acc[S_W-1:0];
        end else begin
            acc    = {1'b0, COEF_K} + {1'b0, term};
            s_next = acc[S_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= valid_in;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= prod_next;
            ra_a_reg    <= ra_in;
            rneg_a_reg  <= rneg_in;
            scale_a_reg <= scale_in;
            s_reg       <= s_next;
            ra_b_reg    <= ra_a_reg;
            rneg_b_reg  <= rneg_a_reg;
            scale_b_reg <= scale_a_reg;
        end
    end

    assign valid_out = vb_reg;
    assign s_out     = s_reg;
    assign ra_out    = ra_b_reg;
    assign rneg_out  = rneg_b_reg;
    assign scale_out = scale_b_reg;

endmodule

FILE: design/ert_scale.sv
// Final scaling: multiplies the Horner sum by the power factor over four
// stages (partial products, two adds, round and clamp). Depends on ert_pkg.
module ert_scale #(
    parameter int OUT_FRAC_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     valid_in,
    input  ert_pkg::sum_t            s_in,
    input  ert_pkg::scale_t          scale_in,
    output logic                     valid_out,
    output logic [OUT_FRAC_BITS+13:0] result_out
);

    localparam int OUT_W  = OUT_FRAC_BITS + 14;
    localparam int S_W    = ert_pkg::S_W;
    localparam int SHI_W  = S_W - 32;
    localparam int PW     = ert_pkg::F_W + S_W + 1;
    localparam int SH_POS = ert_pkg::COEF_FRAC + ert_pkg::POS_FRAC - OUT_FRAC_BITS;
    localparam int SH_NEG = ert_pkg::COEF_FRAC + ert_pkg::NEG_FRAC - OUT_FRAC_BITS;
    localparam int QW     = PW - SH_POS;
    localparam logic [PW-1:0] RND_POS = PW'(1) << (SH_POS - 1);
    localparam logic [PW-1:0] RND_NEG = PW'(1) << (SH_NEG - 1);

    logic [3:0]             v_reg;
    logic                   neg1_reg, neg2_reg, neg3_reg;
    logic [63:0]            ll_reg, hl_reg;
    logic [32+SHI_W-1:0]    lh_reg, hh_reg;
    logic [PW-1:0]          base_reg, full_reg;
    logic [64:0]            mid_reg;
    logic [QW-1:0]          quo;
    logic [OUT_W-1:0]       res_next, res_reg;

    always_comb begin
        quo      = neg3_reg ? QW'(full_reg >> SH_NEG) : QW'(full_reg >> SH_POS);
        res_next = (|quo[QW-1:OUT_W]) ? '1 : quo[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Stage 1: four partial products of the 32-bit factor halves and the 32/29-bit sum halves.
            ll_reg   <= 64'(scale_in.factor[31:0])  * 64'(s_in[31:0]);
            lh_reg   <= (32+SHI_W)'(scale_in.factor[31:0])  * (32+SHI_W)'(s_in[S_W-1:32]);
            hl_reg   <= 64'(scale_in.factor[63:32]) * 64'(s_in[31:0]);
            hh_reg   <= (32+SHI_W)'(scale_in.factor[63:32]) * (32+SHI_W)'(s_in[S_W-1:32]);
            neg1_reg <= scale_in.neg;
            // Stage 2: outer products with the rounding half; cross terms.
            base_reg <= PW'({hh_reg, ll_reg}) + (neg1_reg ? RND_NEG : RND_POS);
            mid_reg  <= 65'(lh_reg) + 65'(hl_reg);
            neg2_reg <= neg1_reg;
            // Stage 3: full rounded product.
            full_reg <= base_reg + (PW'(mid_reg) << 32);
            neg3_reg <= neg2_reg;
            // Stage 4: shift to the output format and clamp.
            res_reg  <= res_next;
        end
    end

    assign valid_out  = v_reg[3];
    assign result_out = res_reg;

endmodule

FILE: design/exp_range_reduced_taylor.sv
// Top level of the e^x block: range reduction, Horner chain, final scaling
// and output skid. Depends on ert_pkg, ert_reduce, ert_horner_step, ert_scale.
//
// Usage
//   s_tvalid/s_tready/s_tdata carry one argument word x per handshake: signed
//   fixed point with IN_FRAC_BITS fraction bits and five integer bits.
//   m_tvalid/m_tready/m_tdata return e^x for each word, in order, unsigned
//   with OUT_FRAC_BITS fraction bits and fourteen integer bits, clamped to
//   all ones if it would not fit.
//   Throughput: one word per cycle while the output is not stalled; every stage is a register.
//   Latency: 2*TERMS+8 register stages (48 at TERMS = 20): three range-reduction
//   stages, two for each Horner step (multiply, then round and add), four
//   scaling stages for the 64 x 61 bit product, and the output register.
//   Stall: while m_tready is low the pipeline keeps running until one extra
//   word lands in the skid register; only then does s_tready fall and the
//   whole pipeline hold. Nothing is dropped or repeated.
//   Reset: aresetn low for one edge empties the pipeline and both output
//   registers; the block takes words on the next cycle.
module exp_range_reduced_taylor #(
    parameter int TERMS         = 20,
    parameter int IN_FRAC_BITS  = 16,
    parameter int OUT_FRAC_BITS = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((IN_FRAC_BITS+5+7)/8)*8-1:0]       s_tdata,   // x_value, zero padded
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((OUT_FRAC_BITS+14+7)/8)*8-1:0]     m_tdata    // exp_result, zero padded
);

    localparam int IN_W      = IN_FRAC_BITS + 5;
    localparam int OUT_W     = OUT_FRAC_BITS + 14;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    logic                    pipe_en;
    logic                    red_valid;
    logic                    h_valid [0:TERMS];
    ert_pkg::sum_t           h_s     [0:TERMS];
    logic [IN_FRAC_BITS-1:0] h_ra    [0:TERMS];
    logic                    h_rneg  [0:TERMS];
    ert_pkg::scale_t         h_scale [0:TERMS];
    logic                    fin_valid;
    logic [OUT_W-1:0]        fin_data;

    logic                    m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]        m_data_reg, m_data_next;
    logic                    skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0]        skid_data_reg, skid_data_next;

    // Advance the whole pipeline unless the skid register holds a word.
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    ert_reduce #(
        .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .valid_in  (s_tvalid),
        .x_in      (s_tdata[IN_W-1:0]),
        .valid_out (red_valid),
        .ra_out    (h_ra[0]),
        .rneg_out  (h_rneg[0]),
        .scale_out (h_scale[0])
    );

    // Horner starts from the highest-order coefficient.
    assign h_valid[0] = red_valid;
    assign h_s[0]     = ert_pkg::sum_t'(ert_pkg::COEF[TERMS]);

    genvar j;
    generate
        for (j = 0; j < TERMS; j++) begin : g_horner
            ert_horner_step #(
                .IN_FRAC_BITS(IN_FRAC_BITS),
                .K           (TERMS - 1 - j)
            ) u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (pipe_en),
                .valid_in  (h_valid[j]),
                .s_in      (h_s[j]),
                .ra_in     (h_ra[j]),
                .rneg_in   (h_rneg[j]),
                .scale_in  (h_scale[j]),
                .valid_out (h_valid[j+1]),
                .s_out     (h_s[j+1]),
                .ra_out    (h_ra[j+1]),
                .rneg_out  (h_rneg[j+1]),
                .scale_out (h_scale[j+1])
            );
        end
    endgenerate

    ert_scale #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .valid_in   (h_valid[TERMS]),
        .s_in       (h_s[TERMS]),
        .scale_in   (h_scale[TERMS]),
        .valid_out  (fin_valid),
        .result_out (fin_data)
    );

    // Output register with a one-word skid behind it.
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (m_valid_reg && !m_tready) begin
            // Output held: park the arriving word in the skid.
            if (pipe_en && fin_valid) begin
                skid_valid_next = 1'b1;
                skid_data_next  = fin_data;
            end
        end else if (skid_valid_reg) begin
            // Drain the skid first; the pipeline is frozen meanwhile.
            m_valid_next    = 1'b1;
            m_data_next     = skid_data_reg;
            skid_valid_next = 1'b0;
        end else begin
            m_valid_next = fin_valid;
            if (fin_valid) begin
                m_data_next = fin_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

`ifndef SYNTHESIS
    // A parked word always sits behind a word on the output.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a word while the output is empty");

    // The skid fills only while the output is stalled.
    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    // A taken output word drains the skid at once.
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> !skid_valid_reg)
        else $error("skid not drained after the output was taken");
`endif

endmodule
